/* sv/sdb_pkg.sv */
`timescale 1ns / 1ps

package sdb_pkg;

    // default geometry: signed Q16.16 in 32 bits
    localparam int SDB_DATA_WIDTH = 32;
    localparam int SDB_FRAC_BITS  = 16;

    // mode register codes
    localparam logic [1:0] SDB_MODE_NONE   = 2'd0;
    localparam logic [1:0] SDB_MODE_FIRST  = 2'd1;
    localparam logic [1:0] SDB_MODE_SECOND = 2'd2;
    localparam logic [1:0] SDB_MODE_XY     = 2'd3;

    // configuration register indexes
    localparam logic SDB_CFG_MODE   = 1'b0;
    localparam logic SDB_CFG_OFFSET = 1'b1;

    // request into the quotient sequencer
    typedef struct packed {
        logic start;   // load operands and run
        logic square;  // square the step before dividing
        logic neg;     // sign of the quotient
    } t_quot_req;

    // status back from the quotient sequencer
    typedef struct packed {
        logic done;    // one-cycle pulse, quotient valid
        logic ovf;     // saturated or zero step
    } t_quot_rsp;

endpackage

/* sv/series_derivative_bounds.sv */
`timescale 1ns / 1ps
// Steps: an accepted sample goes through S_DIFF and then S_BOX and S_OUT in modes 0 and 3; in modes 1
// and 2 it passes S_MAG and the quotient sequencer (square in mode 2, check, divide, fix-up) before S_BOX;
// a zero or saturating step skips the divide; a sample without enough history gives no output.
// The input stalls while busy: a new sample is taken only once the last one is through.
// The restoring divider and the shift-add square of the time step share one adder.
// Reset (i_rst_n low, synchronous): mode 0, offset 0, history and box cleared.

module series_derivative_bounds
    import sdb_pkg::*;
#(
    parameter int DATA_WIDTH = SDB_DATA_WIDTH,
    parameter int FRAC_BITS  = SDB_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // sample channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_sample_time,
    input  logic signed [DATA_WIDTH-1:0] i_sample_value,
    input  logic signed [DATA_WIDTH-1:0] i_alt_time,
    input  logic signed [DATA_WIDTH-1:0] i_alt_value,
    input  logic                         i_series_start,
    // point channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_point_x,
    output logic signed [DATA_WIDTH-1:0] o_point_y,
    output logic signed [DATA_WIDTH-1:0] o_min_x,
    output logic signed [DATA_WIDTH-1:0] o_max_x,
    output logic signed [DATA_WIDTH-1:0] o_min_y,
    output logic signed [DATA_WIDTH-1:0] o_max_y,
    output logic                         o_overflow,
    output logic                         o_mismatch,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic        [DATA_WIDTH-1:0] i_cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam int MW = DATA_WIDTH + 1;

    localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIFF = 6'b000010,
        S_MAG  = 6'b000100,
        S_QUOT = 6'b001000,
        S_BOX  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state       r_state;
    t_state       n_state;

    // configuration
    logic [1:0]    r_mode;
    logic [DW-1:0] r_offset;

    // two-deep history, index 0 newest
    logic [DW-1:0] r_h0t;
    logic [DW-1:0] r_h0v;
    logic [DW-1:0] r_h1t;
    logic [DW-1:0] r_h1v;
    logic [1:0]    r_seen;

    // running box, x held before the offset
    logic [DW-1:0] r_min_x;
    logic [DW-1:0] r_max_x;
    logic [DW-1:0] r_min_y;
    logic [DW-1:0] r_max_y;
    logic          r_mismatch;

    // item under work
    logic [DW-1:0] r_t;
    logic [DW-1:0] r_y;
    logic [DW-1:0] r_at;
    logic [DW-1:0] r_ax;
    logic [DW+1:0] r_nd;
    logic [DW:0]   r_dd;
    logic [DW-1:0] r_px;
    logic [DW-1:0] r_py;
    logic          r_ovf;

    // output register
    logic          r_out_valid;
    logic [DW-1:0] r_o_px;
    logic [DW-1:0] r_o_py;
    logic [DW-1:0] r_o_minx;
    logic [DW-1:0] r_o_maxx;
    logic [DW-1:0] r_o_miny;
    logic [DW-1:0] r_o_maxy;
    logic          r_o_ovf;
    logic          r_o_mis;

    logic          w_in_xfer;
    logic          w_out_xfer;
    logic          w_cfg_xfer;
    logic          w_load;
    logic          w_box_clear;
    logic [DW-1:0] w_tb;
    logic [DW:0]   w_dy;
    logic [DW+1:0] w_n2;
    logic [DW:0]   w_dt;
    logic [DW:0]   w_tsum;
    logic [DW+1:0] w_nd_abs;
    logic [DW:0]   w_dd_abs;
    logic [DW-1:0] w_off;
    logic          w_enough;

    t_quot_req     w_req;
    t_quot_rsp     w_rsp;
    logic [DW-1:0] w_quot;

    // x minus offset, clamped to the signed range
    function automatic logic [DW-1:0] f_sub_sat(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] d;
        begin
            d = {a[DW-1], a} - {b[DW-1], b};
            if (d[DW] != d[DW-1]) begin
                f_sub_sat = d[DW] ? NEG_MIN : POS_MAX;
            end else begin
                f_sub_sat = d[DW-1:0];
            end
        end
    endfunction

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;
    assign w_cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // accept only between items; configuration is always taken
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // a series start or a change of mode drops the box and the sticky flag
    assign w_box_clear = (w_cfg_xfer && (i_cfg_index == SDB_CFG_MODE) &&
                          (i_cfg_data[1:0] != r_mode)) ||
                         (w_in_xfer && i_series_start);

    // differences against the history; mode 1 looks one back, mode 2 two back
    assign w_tb   = (r_mode == SDB_MODE_FIRST) ? r_h0t : r_h1t;
    assign w_dy   = {r_y[DW-1], r_y} - {r_h0v[DW-1], r_h0v};
    assign w_n2   = {{2{r_y[DW-1]}}, r_y} - {r_h0v[DW-1], r_h0v, 1'b0} +
                    {{2{r_h1v[DW-1]}}, r_h1v};
    assign w_dt   = {r_t[DW-1], r_t} - {w_tb[DW-1], w_tb};
    assign w_tsum = {r_t[DW-1], r_t} + {w_tb[DW-1], w_tb};

    assign w_enough = ((r_mode == SDB_MODE_FIRST) && (r_seen != 2'd0)) ||
                      ((r_mode == SDB_MODE_SECOND) && (r_seen == 2'd2));

    // magnitudes and sign for the divider
    assign w_nd_abs = r_nd[DW+1] ? (~r_nd + (DW+2)'(1)) : r_nd;
    assign w_dd_abs = r_dd[DW] ? (~r_dd + (DW+1)'(1)) : r_dd;

    assign w_req.start  = (r_state == S_MAG);
    assign w_req.square = (r_mode == SDB_MODE_SECOND);
    assign w_req.neg    = (r_mode == SDB_MODE_SECOND) ? r_nd[DW+1] : (r_nd[DW+1] ^ r_dd[DW]);

    sdb_quot #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_quot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_num_mag (w_nd_abs[MW-1:0]),
        .i_dt_mag  (w_dd_abs),
        .o_rsp     (w_rsp),
        .o_quot    (w_quot)
    );

    // XY points are not shifted by the offset
    assign w_off = (r_mode == SDB_MODE_XY) ? '0 : r_offset;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                if ((r_mode == SDB_MODE_NONE) || (r_mode == SDB_MODE_XY)) begin
                    n_state = S_BOX;
                end else if (w_enough) begin
                    n_state = S_MAG;
                end else begin
                    // not enough history: drop the result, keep the sample
                    n_state = S_IDLE;
                end
            end
            S_MAG: begin
                n_state = S_QUOT;
            end
            S_QUOT: begin
                if (w_rsp.done) begin
                    n_state = S_BOX;
                end
            end
            S_BOX: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state, configuration, history and box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= SDB_MODE_NONE;
            r_offset    <= '0;
            r_h0t       <= '0;
            r_h0v       <= '0;
            r_h1t       <= '0;
            r_h1v       <= '0;
            r_seen      <= 2'd0;
            r_min_x     <= POS_MAX;
            r_max_x     <= NEG_MIN;
            r_min_y     <= POS_MAX;
            r_max_y     <= NEG_MIN;
            r_mismatch  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_xfer) begin
                case (i_cfg_index)
                    SDB_CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                    SDB_CFG_OFFSET: r_offset <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_DIFF: begin
                    // advance the history
                    r_h1t <= r_h0t;
                    r_h1v <= r_h0v;
                    r_h0t <= r_t;
                    r_h0v <= r_y;
                    if (r_seen != 2'd2) begin
                        r_seen <= r_seen + 2'd1;
                    end
                    if ((r_mode == SDB_MODE_XY) && (r_at != r_t)) begin
                        r_mismatch <= 1'b1;
                    end
                end
                S_BOX: begin
                    if ($signed(r_px) < $signed(r_min_x)) r_min_x <= r_px;
                    if ($signed(r_px) > $signed(r_max_x)) r_max_x <= r_px;
                    if ($signed(r_py) < $signed(r_min_y)) r_min_y <= r_py;
                    if ($signed(r_py) > $signed(r_max_y)) r_max_y <= r_py;
                end
                default: ;
            endcase

            if (w_box_clear) begin
                r_min_x    <= POS_MAX;
                r_max_x    <= NEG_MIN;
                r_min_y    <= POS_MAX;
                r_max_y    <= NEG_MIN;
                r_mismatch <= 1'b0;
            end

            // series start: drop the history before the sample is handled
            if (w_in_xfer && i_series_start) begin
                r_h0t  <= '0;
                r_h0v  <= '0;
                r_h1t  <= '0;
                r_h1v  <= '0;
                r_seen <= 2'd0;
            end

            // a load in the same cycle as a transfer out keeps valid high
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_t  <= i_sample_time;
            r_y  <= i_sample_value;
            r_at <= i_alt_time;
            r_ax <= i_alt_value;
        end

        if (r_state == S_DIFF) begin
            r_nd  <= (r_mode == SDB_MODE_SECOND) ? w_n2 : {w_dy[DW], w_dy};
            r_dd  <= w_dt;
            r_py  <= r_y;
            r_ovf <= 1'b0;
            case (r_mode)
                SDB_MODE_NONE: r_px <= r_t;
                SDB_MODE_XY:   r_px <= r_ax;
                // midpoint, rounded toward minus infinity
                default:       r_px <= w_tsum[DW:1];
            endcase
        end

        if ((r_state == S_QUOT) && w_rsp.done) begin
            r_py  <= w_quot;
            r_ovf <= w_rsp.ovf;
        end

        if (w_load) begin
            r_o_px   <= f_sub_sat(r_px, w_off);
            r_o_py   <= r_py;
            r_o_minx <= f_sub_sat(r_min_x, w_off);
            r_o_maxx <= f_sub_sat(r_max_x, w_off);
            r_o_miny <= r_min_y;
            r_o_maxy <= r_max_y;
            r_o_ovf  <= r_ovf;
            r_o_mis  <= r_mismatch;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_o_px;
    assign o_point_y   = r_o_py;
    assign o_min_x     = r_o_minx;
    assign o_max_x     = r_o_maxx;
    assign o_min_y     = r_o_miny;
    assign o_max_y     = r_o_maxy;
    assign o_overflow  = r_o_ovf;
    assign o_mismatch  = r_o_mis;

endmodule

/* sv/sdb_alu.sv */
`timescale 1ns / 1ps

module sdb_alu #(
    parameter int WIDTH = 67
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_carry
);

    logic [WIDTH:0] w_full;

    // a + b, or a - b with carry high when a >= b
    assign w_full  = {1'b0, i_a} + {1'b0, i_b ^ {WIDTH{i_sub}}} + {{WIDTH{1'b0}}, i_sub};
    assign o_sum   = w_full[WIDTH-1:0];
    assign o_carry = w_full[WIDTH];

endmodule

/* sv/sdb_quot.sv */
`timescale 1ns / 1ps

module sdb_quot
    import sdb_pkg::*;
#(
    parameter int DATA_WIDTH = SDB_DATA_WIDTH,
    parameter int FRAC_BITS  = SDB_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_quot_req             i_req,
    input  logic [DATA_WIDTH:0]   i_num_mag,
    input  logic [DATA_WIDTH:0]   i_dt_mag,
    output t_quot_rsp             o_rsp,
    output logic [DATA_WIDTH-1:0] o_quot
);

    localparam int MW   = DATA_WIDTH + 1;
    localparam int SH1  = FRAC_BITS;
    localparam int SH2  = 2 + 2 * FRAC_BITS;
    localparam int NW   = MW + SH2;
    localparam int DENW = 2 * MW;
    localparam int HW   = NW - DATA_WIDTH;
    localparam int XW   = (DENW > HW) ? DENW : HW;
    localparam int AW   = XW + 1;
    localparam int CW   = $clog2(MW + 1);

    localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] NEG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [4:0] {
        Q_IDLE  = 5'b00001,
        Q_MUL   = 5'b00010,
        Q_CHECK = 5'b00100,
        Q_DIV   = 5'b01000,
        Q_FIX   = 5'b10000
    } t_qstate;

    t_qstate               r_state;
    logic [CW-1:0]         r_cnt;
    logic                  r_done;
    logic [NW-1:0]         r_num;
    logic [DENW-1:0]       r_den;
    logic [MW-1:0]         r_mcand;
    logic [DENW-1:0]       r_rem;
    logic [DATA_WIDTH-1:0] r_low;
    logic [DATA_WIDTH-1:0] r_q;
    logic                  r_neg;
    logic [DATA_WIDTH-1:0] r_quot;
    logic                  r_ovf;

    logic [AW-1:0]         w_a;
    logic [AW-1:0]         w_b;
    logic                  w_sub;
    logic [AW-1:0]         w_sum;
    logic                  w_carry;
    logic                  w_den_zero;
    logic [DATA_WIDTH-1:0] w_lim;
    logic [DATA_WIDTH-1:0] w_sat;

    // operand select for the shared adder
    always_comb begin
        case (r_state)
            Q_MUL: begin
                w_a   = AW'(r_den[DENW-1:MW]);
                w_b   = r_den[0] ? AW'(r_mcand) : '0;
                w_sub = 1'b0;
            end
            Q_CHECK: begin
                w_a   = AW'(r_num[NW-1:DATA_WIDTH]);
                w_b   = AW'(r_den);
                w_sub = 1'b1;
            end
            Q_DIV: begin
                w_a   = AW'({r_rem, r_low[DATA_WIDTH-1]});
                w_b   = AW'(r_den);
                w_sub = 1'b1;
            end
            default: begin
                w_a   = '0;
                w_b   = '0;
                w_sub = 1'b0;
            end
        endcase
    end

    sdb_alu #(
        .WIDTH (AW)
    ) u_alu (
        .i_a     (w_a),
        .i_b     (w_b),
        .i_sub   (w_sub),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    assign w_den_zero = (r_den == '0);
    assign w_lim      = r_neg ? NEG_MIN : POS_MAX;
    assign w_sat      = r_neg ? NEG_MIN : POS_MAX;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            // pulse done on an early exit from the check or after the fix-up
            r_done <= ((r_state == Q_CHECK) && (w_den_zero || w_carry)) ||
                      (r_state == Q_FIX);
            case (r_state)
                Q_IDLE: begin
                    if (i_req.start) begin
                        r_state <= i_req.square ? Q_MUL : Q_CHECK;
                        r_cnt   <= '0;
                    end
                end
                Q_MUL: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(MW - 1)) begin
                        r_state <= Q_CHECK;
                    end
                end
                Q_CHECK: begin
                    r_cnt <= '0;
                    if (w_den_zero || w_carry) begin
                        r_state <= Q_IDLE;
                    end else begin
                        r_state <= Q_DIV;
                    end
                end
                Q_DIV: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(DATA_WIDTH - 1)) begin
                        r_state <= Q_FIX;
                    end
                end
                Q_FIX: begin
                    r_state <= Q_IDLE;
                end
                default: begin
                    r_state <= Q_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            Q_IDLE: begin
                if (i_req.start) begin
                    r_num   <= i_req.square ? (NW'(i_num_mag) << SH2) : (NW'(i_num_mag) << SH1);
                    r_den   <= DENW'(i_dt_mag);
                    r_mcand <= i_dt_mag;
                    r_neg   <= i_req.neg;
                end
            end
            Q_MUL: begin
                // shift-add square: add the step into the high half, shift right
                r_den <= {w_sum[MW:0], r_den[MW-1:1]};
            end
            Q_CHECK: begin
                if (w_den_zero) begin
                    r_quot <= (r_num == '0) ? '0 : w_sat;
                    r_ovf  <= 1'b1;
                end else if (w_carry) begin
                    // quotient needs more than DATA_WIDTH bits
                    r_quot <= w_sat;
                    r_ovf  <= 1'b1;
                end else begin
                    r_rem <= DENW'(r_num[NW-1:DATA_WIDTH]);
                    r_low <= r_num[DATA_WIDTH-1:0];
                    r_q   <= '0;
                end
            end
            Q_DIV: begin
                r_rem <= w_carry ? DENW'(w_sum) : DENW'({r_rem, r_low[DATA_WIDTH-1]});
                r_low <= {r_low[DATA_WIDTH-2:0], 1'b0};
                r_q   <= {r_q[DATA_WIDTH-2:0], w_carry};
            end
            Q_FIX: begin
                if (r_q > w_lim) begin
                    r_quot <= w_sat;
                    r_ovf  <= 1'b1;
                end else begin
                    r_quot <= r_neg ? (~r_q + DATA_WIDTH'(1)) : r_q;
                    r_ovf  <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_quot     = r_quot;

endmodule
